// ===== hdl/isa_pkg.sv =====
// Package: types, operation codes and constants for the integer stack ALU.
`timescale 1ns / 1ps
package isa_pkg;
	localparam int DefStackDepth = 256;
	localparam int MinArith = 2;
	localparam int MinConv = 1;

	localparam logic [5:0] OP_PUSH = 6'd0, OP_POP = 6'd1, OP_PEEK = 6'd2, OP_CLEAR = 6'd3,
		OP_DUP = 6'd4, OP_MUL = 6'd5, OP_MULS = 6'd6, OP_DIV = 6'd7, OP_DIVS = 6'd8,
		OP_MOD = 6'd9, OP_MODS = 6'd10, OP_POW = 6'd11, OP_POWS = 6'd12, OP_ADD = 6'd13,
		OP_SUB = 6'd14, OP_LINV = 6'd15, OP_LAND = 6'd16, OP_LOR = 6'd17, OP_LXOR = 6'd18,
		OP_BINV = 6'd19, OP_BAND = 6'd20, OP_BOR = 6'd21, OP_BXOR = 6'd22, OP_EQ = 6'd23,
		OP_NE = 6'd24, OP_LT = 6'd25, OP_GT = 6'd26, OP_LE = 6'd27, OP_GE = 6'd28,
		OP_LTS = 6'd29, OP_GTS = 6'd30, OP_LES = 6'd31, OP_GES = 6'd32;

	localparam logic [2:0] ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_FULL = 3'd2, ST_FEW = 3'd3,
		ST_DIV0 = 3'd4;

	typedef struct packed {
		logic [5:0]  kind;
		logic [63:0] push_value;
	} req_t;

	typedef struct packed {
		logic [63:0] read_value;
		logic [2:0]  status;
		logic [8:0]  depth;
	} rsp_t;
endpackage

// ===== hdl/isa_ram.sv =====
// Generic single-port-write RAM with one registered read port.
`timescale 1ns / 1ps
module isa_ram #(
	parameter int Width = 64,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/isa_seq.sv =====
// Multi-cycle arithmetic unit: 32x32 partial-product multiply, power, restoring divide.
`timescale 1ns / 1ps
module isa_seq (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [1:0]  op,      // 0 mul, 1 pow, 2 div
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] prod,
	output logic [63:0] quot,
	output logic [63:0] rem
);
	localparam logic [1:0] U_MUL = 2'd0, U_POW = 2'd1, U_DIV = 2'd2;
	localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_POW = 3'd2, S_DIV = 3'd3,
		S_DONE = 3'd4;

	logic [2:0]  state_q;
	logic [1:0]  op_q;
	logic [63:0] x_q, y_q, acc_q, p_q, q_q, r_q;
	logic [1:0]  pp_q;      // partial product index
	logic        which_q;   // pow: 0 multiply acc, 1 square base
	logic [6:0]  cnt_q;
	logic [63:0] m_a, m_b, mres_q;
	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [64:0] rtrial;

	// One 32x32 partial product per cycle; low 64 bits of a 64x64 product need three.
	always_comb begin
		case (pp_q)
			2'd0: begin pa = m_a[31:0]; pb = m_b[31:0]; end
			2'd1: begin pa = m_a[63:32]; pb = m_b[31:0]; end
			default: begin pa = m_a[31:0]; pb = m_b[63:32]; end
		endcase
	end
	assign pp = pa * pb;
	assign m_a = (op_q == U_POW && which_q == 1'b0) ? acc_q : x_q;
	assign m_b = (op_q == U_POW && which_q == 1'b0) ? x_q : (op_q == U_POW ? x_q : y_q);
	assign rtrial = {r_q, q_q[63]} - {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (go) begin
						op_q <= op; x_q <= a; y_q <= b; p_q <= b;
						acc_q <= 64'd1; pp_q <= 2'd0; mres_q <= '0;
						r_q <= '0; q_q <= a; cnt_q <= '0; which_q <= 1'b0;
						case (op)
							U_MUL: state_q <= S_MUL;
							U_POW: state_q <= S_POW;
							default: state_q <= S_DIV;
						endcase
					end
				end
				S_MUL: begin
					case (pp_q)
						2'd0: mres_q <= pp;
						default: mres_q <= mres_q + {pp[31:0], 32'd0};
					endcase
					if (pp_q == 2'd2) begin
						state_q <= S_DONE;
					end
					pp_q <= pp_q + 2'd1;
				end
				S_POW: begin
					// Each bit: optional multiply into acc, then square base.
					if (pp_q == 2'd3) begin
						pp_q <= 2'd0;
						mres_q <= '0;
						if (which_q == 1'b0) begin
							if (p_q[0]) acc_q <= mres_q;
							which_q <= 1'b1;
						end else begin
							x_q <= mres_q;
							p_q <= p_q >> 1;
							which_q <= 1'b0;
							if ((p_q >> 1) == 64'd0) state_q <= S_DONE;
						end
					end else if (p_q == 64'd0) begin
						state_q <= S_DONE;
					end else if (which_q == 1'b0 && !p_q[0]) begin
						which_q <= 1'b1;
					end else begin
						case (pp_q)
							2'd0: mres_q <= pp;
							default: mres_q <= mres_q + {pp[31:0], 32'd0};
						endcase
						pp_q <= pp_q + 2'd1;
					end
				end
				S_DIV: begin
					if (!rtrial[64]) begin
						r_q <= rtrial[63:0];
						q_q <= {q_q[62:0], 1'b1};
					end else begin
						r_q <= {r_q[62:0], q_q[63]};
						q_q <= {q_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) state_q <= S_DONE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = (state_q == S_DONE);
	assign prod = (op_q == U_POW) ? acc_q : mres_q;
	assign quot = q_q;
	assign rem = r_q;
endmodule

// ===== hdl/integer_stack_alu.sv =====
// Top level: operand stack in a RAM with an integer ALU.
`timescale 1ns / 1ps
// One request at a time. start is taken when busy is low; the result appears on
// result with done high for one cycle and cannot be held off. done rises in the cycle in
// which busy falls. Push, pop, peek, clear, logic, bitwise, add and compare hold busy
// through RAM reads of top and second, execute, status check and write-back. Multiply,
// divide, modulo and power also hold it in the status check until the sequencer is done;
// the bit-per-cycle divider runs the divide, and power a square-and-multiply loop over up
// to 64 exponent bits with a 3-step multiplier. The stack RAM needs no clearing after reset.
module integer_stack_alu
	#(parameter int StackDepth = isa_pkg::DefStackDepth) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  isa_pkg::req_t   request,
	output logic            done,
	output isa_pkg::rsp_t   result,
	input  logic            cfg_we,
	input  logic [8:0]      cfg_wdata
);
	import isa_pkg::*;
	localparam int AW = $clog2(StackDepth);
	localparam int CW = $clog2(StackDepth + 1);

	localparam logic [2:0] S_IDLE = 3'd0, S_RD1 = 3'd1, S_RD2 = 3'd2, S_EXEC = 3'd3,
		S_WAIT = 3'd4, S_WB = 3'd5;

	logic [2:0]    state_q;
	logic [8:0]    limit_q;
	logic [CW-1:0] cnt_q;
	logic [5:0]    kind_q;
	logic [63:0]   pv_q, r_q, l_q, res_q;
	logic [2:0]    st_q;
	logic [63:0]   rsp_value_q;
	logic [2:0]    rsp_status_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0]   wdata, rdata;
	logic          sgo, sdone;
	logic [1:0]    sop;
	logic [63:0]   sa, sb, sprod, squot, srem;
	logic [CW:0]   eff;
	logic [63:0]   alu;
	logic          is_bin, is_un, is_div, is_mul, is_pow;
	logic [63:0]   ml, mr;
	logic          lneg, rneg;

	isa_ram #(.Width(64), .Depth(StackDepth)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

	isa_seq u_seq (
		.clk(clk), .arst_n(arst_n), .go(sgo), .op(sop), .a(sa), .b(sb),
		.done(sdone), .prod(sprod), .quot(squot), .rem(srem));

	// Effective limit clamped to [2, StackDepth].
	always_comb begin
		if ({{(CW+1){1'b0}}, limit_q} < (CW+1+9)'(2)) eff = (CW+1)'(2);
		else if ({{(CW+1){1'b0}}, limit_q} > (CW+1+9)'(StackDepth)) eff = (CW+1)'(StackDepth);
		else eff = (CW+1)'(limit_q);
	end

	assign is_un  = (kind_q == OP_LINV) || (kind_q == OP_BINV);
	assign is_bin = (kind_q >= OP_MUL) && (kind_q <= OP_GES) && !is_un;
	assign is_div = (kind_q >= OP_DIV) && (kind_q <= OP_MODS);
	assign is_mul = (kind_q == OP_MUL) || (kind_q == OP_MULS);
	assign is_pow = (kind_q == OP_POW) || (kind_q == OP_POWS);
	assign lneg = l_q[63];
	assign rneg = r_q[63];
	assign ml = lneg ? -l_q : l_q;
	assign mr = rneg ? -r_q : r_q;

	always_comb begin
		case (kind_q)
			OP_ADD:  alu = l_q + r_q;
			OP_SUB:  alu = l_q - r_q;
			OP_LINV: alu = {63'd0, r_q == 64'd0};
			OP_BINV: alu = ~r_q;
			OP_LAND: alu = {63'd0, (l_q != 64'd0) && (r_q != 64'd0)};
			OP_LOR:  alu = {63'd0, (l_q != 64'd0) || (r_q != 64'd0)};
			OP_LXOR: alu = {63'd0, (l_q != 64'd0) != (r_q != 64'd0)};
			OP_BAND: alu = l_q & r_q;
			OP_BOR:  alu = l_q | r_q;
			OP_BXOR: alu = l_q ^ r_q;
			OP_EQ:   alu = {63'd0, l_q == r_q};
			OP_NE:   alu = {63'd0, l_q != r_q};
			OP_LT:   alu = {63'd0, l_q < r_q};
			OP_GT:   alu = {63'd0, l_q > r_q};
			OP_LE:   alu = {63'd0, l_q <= r_q};
			OP_GE:   alu = {63'd0, l_q >= r_q};
			OP_LTS:  alu = {63'd0, $signed(l_q) < $signed(r_q)};
			OP_GTS:  alu = {63'd0, $signed(l_q) > $signed(r_q)};
			OP_LES:  alu = {63'd0, $signed(l_q) <= $signed(r_q)};
			OP_GES:  alu = {63'd0, $signed(l_q) >= $signed(r_q)};
			default: alu = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		sop = is_mul ? 2'd0 : (is_pow ? 2'd1 : 2'd2);
		sa = (kind_q == OP_DIVS || kind_q == OP_MODS) ? ml : l_q;
		sb = (kind_q == OP_DIVS || kind_q == OP_MODS || kind_q == OP_POWS) ? mr : r_q;
		// launch only when both operands exist
		sgo = (state_q == S_EXEC) && (cnt_q >= CW'(MinArith)) && (is_mul || is_pow || is_div)
			&& (r_q != 64'd0 || !is_div) && !(kind_q == OP_POWS && lneg);
	end

	always_comb begin
		raddr = '0;
		if (state_q == S_IDLE) raddr = AW'(cnt_q - CW'(1));
		else raddr = AW'(cnt_q - CW'(2));
		we = 1'b0;
		waddr = AW'(cnt_q - CW'(2));
		wdata = res_q;
		if (state_q == S_WB && st_q == ST_OK) begin
			case (kind_q)
				OP_PUSH: begin we = 1'b1; waddr = AW'(cnt_q); wdata = pv_q; end
				OP_DUP:  begin we = 1'b1; waddr = AW'(cnt_q); wdata = r_q; end
				OP_LINV, OP_BINV: begin we = 1'b1; waddr = AW'(cnt_q - CW'(1)); end
				default: we = is_bin;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limit_q <= 9'd256;
			cnt_q <= '0;
			done <= 1'b0;
			rsp_value_q <= '0;
			rsp_status_q <= ST_OK;
		end else begin
			done <= 1'b0;
			if (cfg_we) limit_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q <= request.kind;
						pv_q <= request.push_value;
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					// top arrives, second issued
					r_q <= rdata;
					state_q <= S_RD2;
				end
				S_RD2: begin
					l_q <= rdata;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					st_q <= ST_OK;
					res_q <= '0;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					// status checks and ALU result
					state_q <= S_WB;
					if (kind_q == OP_PUSH || kind_q == OP_DUP) begin
						if (kind_q == OP_DUP && cnt_q == '0) st_q <= ST_EMPTY;
						else if ({1'b0, cnt_q} >= eff) st_q <= ST_FULL;
					end else if (kind_q == OP_POP || kind_q == OP_PEEK) begin
						if (cnt_q == '0) st_q <= ST_EMPTY;
						else res_q <= r_q;
					end else if (is_un) begin
						if (cnt_q < CW'(MinConv)) st_q <= ST_FEW;
						else res_q <= alu;
					end else if (is_bin) begin
						if (cnt_q < CW'(MinArith)) st_q <= ST_FEW;
						else if (is_div && r_q == 64'd0) st_q <= ST_DIV0;
						else if (kind_q == OP_POWS && lneg) res_q <= '0;
						else if (is_mul || is_pow || is_div) begin
							if (!sdone) state_q <= S_WAIT;
							else case (kind_q)
								OP_DIV: res_q <= squot;
								OP_MOD: res_q <= srem;
								OP_DIVS: res_q <= (lneg ^ rneg) ? -squot : squot;
								OP_MODS: res_q <= lneg ? -srem : srem;
								default: res_q <= sprod;
							endcase
						end else res_q <= alu;
					end
				end
				S_WB: begin
					done <= 1'b1;
					rsp_status_q <= st_q;
					rsp_value_q <= ((kind_q == OP_POP || kind_q == OP_PEEK) && st_q == ST_OK)
						? res_q : 64'd0;
					state_q <= S_IDLE;
					if (st_q == ST_OK) begin
						case (kind_q)
							OP_PUSH, OP_DUP: cnt_q <= cnt_q + CW'(1);
							OP_POP: cnt_q <= cnt_q - CW'(1);
							OP_CLEAR: cnt_q <= '0;
							default: if (is_bin) cnt_q <= cnt_q - CW'(1);
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Depth reported after the update.
	always_comb begin
		result.read_value = rsp_value_q;
		result.status = rsp_status_q;
		result.depth = 9'(cnt_q);
	end
endmodule

// ===== dv/tb_integer_stack_alu.sv =====
// Testbench: integer stack ALU checked against a behavioral stack model.
`timescale 1ns / 1ps
module tb_integer_stack_alu;
	import isa_pkg::*;

	localparam int Depth = DefStackDepth;
	localparam int NumRandom = 1900;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t request = '0;
	logic done;
	rsp_t result;
	logic cfg_we = 1'b0;
	logic [8:0] cfg_wdata = '0;

	integer_stack_alu dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("tb_integer_stack_alu: errors");
		$finish;
	end

	// behavioral copy of the stack
	logic [63:0] words [Depth];
	int unsigned word_count;
	logic [8:0] limit_reg;
	rsp_t pending_rsp [$];
	int unsigned mismatches;
	int unsigned requests_sent;
	int unsigned status_seen [5];
	int sender_idle_pct;

	function automatic logic [63:0] magnitude(logic [63:0] v);
		return v[63] ? -v : v;
	endfunction

	function automatic logic [63:0] power_wrap(logic [63:0] x, logic [63:0] p);
		logic [63:0] r;
		r = 64'd1;
		while (p != 0) begin
			if (p[0]) r = r * x;
			x = x * x;
			p = p >> 1;
		end
		return r;
	endfunction

	function automatic rsp_t stack_step(req_t rq);
		rsp_t o;
		logic [63:0] l, r, res;
		int unsigned lim, n;
		n = word_count;
		o = '0;
		res = '0;
		lim = limit_reg < 2 ? 2 : (limit_reg > Depth ? Depth : limit_reg);
		if (rq.kind == OP_PUSH || rq.kind == OP_DUP) begin
			if (rq.kind == OP_DUP && n == 0) o.status = ST_EMPTY;
			else if (n >= lim) o.status = ST_FULL;
			else begin
				words[n] = rq.kind == OP_PUSH ? rq.push_value : words[n - 1];
				word_count = n + 1;
			end
		end else if (rq.kind == OP_POP || rq.kind == OP_PEEK) begin
			if (n == 0) o.status = ST_EMPTY;
			else begin
				o.read_value = words[n - 1];
				if (rq.kind == OP_POP) word_count = n - 1;
			end
		end else if (rq.kind == OP_CLEAR) begin
			word_count = 0;
		end else if (rq.kind == OP_LINV || rq.kind == OP_BINV) begin
			if (n < MinConv) o.status = ST_FEW;
			else if (rq.kind == OP_LINV) words[n - 1] = {63'd0, words[n - 1] == 0};
			else words[n - 1] = ~words[n - 1];
		end else if (rq.kind <= OP_GES) begin
			if (n < MinArith) o.status = ST_FEW;
			else begin
				r = words[n - 1];
				l = words[n - 2];
				case (rq.kind)
					OP_MUL, OP_MULS: res = l * r;
					OP_DIV: if (r == 0) o.status = ST_DIV0; else res = l / r;
					OP_DIVS: begin
						if (r == 0) o.status = ST_DIV0;
						else begin
							res = magnitude(l) / magnitude(r);
							if (l[63] ^ r[63]) res = -res;
						end
					end
					OP_MOD: if (r == 0) o.status = ST_DIV0; else res = l % r;
					OP_MODS: begin
						if (r == 0) o.status = ST_DIV0;
						else begin
							res = magnitude(l) % magnitude(r);
							if (l[63]) res = -res;
						end
					end
					OP_POW: res = power_wrap(l, r);
					OP_POWS: res = l[63] ? 64'd0 : power_wrap(l, magnitude(r));
					OP_ADD: res = l + r;
					OP_SUB: res = l - r;
					OP_LAND: res = (l != 0) && (r != 0);
					OP_LOR: res = (l != 0) || (r != 0);
					OP_LXOR: res = (l != 0) != (r != 0);
					OP_BAND: res = l & r;
					OP_BOR: res = l | r;
					OP_BXOR: res = l ^ r;
					OP_EQ: res = l == r;
					OP_NE: res = l != r;
					OP_LT: res = l < r;
					OP_GT: res = l > r;
					OP_LE: res = l <= r;
					OP_GE: res = l >= r;
					OP_LTS: res = $signed(l) < $signed(r);
					OP_GTS: res = $signed(l) > $signed(r);
					OP_LES: res = $signed(l) <= $signed(r);
					default: res = $signed(l) >= $signed(r);
				endcase
				if (o.status == ST_OK) begin
					words[n - 2] = res;
					word_count = n - 1;
				end
			end
		end
		o.depth = word_count[8:0];
		return o;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (done) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", result);
			end else begin
				want = pending_rsp.pop_front();
				if (result.status <= ST_DIV0) status_seen[result.status]++;
				if (result.read_value !== want.read_value || result.status !== want.status ||
						result.depth !== want.depth) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
							want.read_value, want.status, want.depth,
							result.read_value, result.status, result.depth);
				end
			end
		end
	end

	// send one request, optionally checking against a typed-in answer too
	task automatic issue(req_t rq, logic check_typed, rsp_t typed);
		rsp_t predicted;
		// step off the edge that dropped start, then idle at random
		do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		start <= 1'b1;
		request <= rq;
		do @(posedge clk); while (busy);
		predicted = stack_step(rq);
		if (check_typed && predicted !== typed) begin
			mismatches++;
			if (mismatches <= 10) $display("typed row mismatch for kind %0d", rq.kind);
		end
		pending_rsp.push_back(predicted);
		requests_sent++;
		start <= 1'b0;
	endtask

	task automatic set_limit(logic [8:0] v);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_reg = v;
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(7))
			0: return 64'd0;
			1: return {64{1'b1}};
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h7fff_ffff_ffff_ffff;
			4: return {60'd0, 4'($urandom)};
			5: return {64{1'b1}} - 64'($urandom_range(5));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	typedef struct {
		logic [5:0] kind;
		logic [63:0] val;
		logic typed;
		rsp_t want;
	} row_t;

	row_t plan [] = '{
		'{OP_POP, 64'd0, 1'b1, '{64'd0, ST_EMPTY, 9'd0}},
		'{OP_PEEK, 64'd0, 1'b1, '{64'd0, ST_EMPTY, 9'd0}},
		'{OP_DUP, 64'd0, 1'b1, '{64'd0, ST_EMPTY, 9'd0}},
		'{OP_ADD, 64'd0, 1'b1, '{64'd0, ST_FEW, 9'd0}},
		'{OP_BINV, 64'd0, 1'b1, '{64'd0, ST_FEW, 9'd0}},
		'{OP_PUSH, 64'h8000_0000_0000_0000, 1'b1, '{64'd0, ST_OK, 9'd1}},
		'{OP_MUL, 64'd0, 1'b1, '{64'd0, ST_FEW, 9'd1}},
		'{OP_PUSH, {64{1'b1}}, 1'b1, '{64'd0, ST_OK, 9'd2}},
		'{OP_DIVS, 64'd0, 1'b0, '0},
		'{OP_PEEK, 64'd0, 1'b1, '{64'h8000_0000_0000_0000, ST_OK, 9'd1}},
		'{OP_PUSH, {64{1'b1}}, 1'b0, '0},
		'{OP_MODS, 64'd0, 1'b0, '0},
		'{OP_PUSH, 64'd0, 1'b0, '0},
		'{OP_DIV, 64'd0, 1'b1, '{64'd0, ST_DIV0, 9'd2}},
		'{OP_MOD, 64'd0, 1'b1, '{64'd0, ST_DIV0, 9'd2}},
		'{OP_POWS, 64'd0, 1'b0, '0},
		'{OP_DUP, 64'd0, 1'b0, '0},
		'{OP_LINV, 64'd0, 1'b0, '0},
		'{OP_PUSH, 64'd3, 1'b0, '0},
		'{OP_POW, 64'd0, 1'b0, '0},
		'{6'd63, 64'd0, 1'b0, '0},
		'{OP_GES, 64'd0, 1'b0, '0},
		'{OP_POP, 64'd0, 1'b0, '0},
		'{OP_CLEAR, 64'd0, 1'b1, '{64'd0, ST_OK, 9'd0}}
	};

	initial begin
		req_t rq;
		int unsigned phase_len;
		limit_reg = 9'd256;
		word_count = 0;
		sender_idle_pct = 22;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) begin
			rq.kind = plan[i].kind;
			rq.push_value = plan[i].val;
			issue(rq, plan[i].typed, plan[i].want);
		end

		phase_len = NumRandom / 3;
		for (int ph = 0; ph < 3; ph++) begin
			sender_idle_pct = ph == 0 ? 22 : (ph == 1 ? 87 : 0);
			case (ph)
				0: set_limit(9'd0);
				1: set_limit(9'd511);
				default: set_limit(9'($urandom_range(2, 40)));
			endcase
			for (int k = 0; k < phase_len; k++) begin
				if (k == phase_len / 2) set_limit(9'($urandom_range(0, 511)));
				case ($urandom_range(9))
					0, 1, 2: rq.kind = OP_PUSH;
					3: rq.kind = 6'($urandom_range(OP_POP, OP_DUP));
					4: rq.kind = $urandom_range(19) == 0 ? 6'($urandom_range(33, 63)) : OP_CLEAR;
					default: rq.kind = 6'($urandom_range(OP_MUL, OP_GES));
				endcase
				if (rq.kind == OP_CLEAR && $urandom_range(3) != 0) rq.kind = OP_ADD;
				rq.push_value = rand_word();
				// zero the push value of most power requests (power takes its operands from the stack)
				if ((rq.kind == OP_POW || rq.kind == OP_POWS) && $urandom_range(3) != 0)
					rq.push_value = 0;
				issue(rq, 1'b0, '0);
			end
			// in the last phase, push 45 more words toward the limit
			if (ph == 2)
				for (int k = 0; k < 45; k++) begin
					rq.kind = OP_PUSH;
					rq.push_value = rand_word();
					issue(rq, 1'b0, '0);
				end
		end

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		$display("requests %0d; status ok %0d empty %0d full %0d few %0d div0 %0d",
			requests_sent, status_seen[0], status_seen[1], status_seen[2],
			status_seen[3], status_seen[4]);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("tb_integer_stack_alu: clean");
		else
			$display("tb_integer_stack_alu: errors");
		$finish;
	end
endmodule
